/* src/bpd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the BMP pixel stream decoder.
// No dependencies; used by every module of the block.
package bpd_pkg;

  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned HCNT_W     = 6;

  localparam logic [HCNT_W-1:0] HEADER_LEN  = HCNT_W'(54);
  localparam logic [HCNT_W-1:0] WIDTH_OFS   = HCNT_W'(18);
  localparam logic [HCNT_W-1:0] HEIGHT_OFS  = HCNT_W'(22);
  localparam logic [HCNT_W-1:0] BITS_OFS    = HCNT_W'(28);
  localparam logic [HCNT_W-1:0] FIELD_BYTES = HCNT_W'(4);
  localparam logic [HCNT_W-1:0] BITS_BYTES  = HCNT_W'(2);

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } phase_t;

  typedef struct packed {
    logic             last_pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
  } pixel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [31:0] raw,
                                                  input logic [31:0] limit);
    logic [DIM_W-1:0] res;
    if (raw[31]) begin
      res = '0;
    end else if (raw > limit) begin
      res = limit[DIM_W-1:0];
    end else begin
      res = raw[DIM_W-1:0];
    end
    return res;
  endfunction

endpackage

/* src/bpd_parser.sv */
`timescale 1ns / 1ps
// Front part: accepts file bytes, parses the header and assembles pixels.
// Depends on bpd_pkg; pushes finished pixels into bpd_queue.
module bpd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_first,
  input  bpd_pkg::queue_status_t q_status,
  output logic                  push,
  output bpd_pkg::pixel_t       push_data
);

  logic                          parse_active;
  logic [bpd_pkg::HCNT_W-1:0]    header_count;
  logic [31:0]                   raw_width;
  logic [31:0]                   raw_height;
  logic [15:0]                   bit_count;
  logic [bpd_pkg::DIM_W-1:0]     image_width;
  logic [bpd_pkg::DIM_W-1:0]     image_height;
  logic [1:0]                    pad_length;
  logic [1:0]                    pad_left;
  logic [bpd_pkg::POS_W-1:0]     col_counter;
  logic [bpd_pkg::DIM_W-1:0]     row_counter;
  bpd_pkg::phase_t               byte_phase;
  logic [7:0]                    held_blue;
  logic [7:0]                    held_green;

  logic                          accept;
  logic                          in_header;
  logic                          in_image;
  logic                          col_last;
  logic                          row_last;
  logic [bpd_pkg::HCNT_W-1:0]    width_idx;
  logic [bpd_pkg::HCNT_W-1:0]    height_idx;
  logic [bpd_pkg::HCNT_W-1:0]    bits_idx;
  logic [bpd_pkg::DIM_W-1:0]     width_clamped;
  logic [1:0]                    pad_prod;

  assign in_ready   = !q_status.full;
  assign accept     = in_valid && in_ready;
  assign in_header  = header_count < bpd_pkg::HEADER_LEN;
  assign in_image   = (image_width != '0) && (row_counter < image_height);
  assign col_last   = ({1'b0, col_counter} + 1'b1) == image_width;
  assign row_last   = (row_counter + 1'b1) == image_height;
  assign width_idx  = header_count - bpd_pkg::WIDTH_OFS;
  assign height_idx = header_count - bpd_pkg::HEIGHT_OFS;
  assign bits_idx   = header_count - bpd_pkg::BITS_OFS;

  assign width_clamped = bpd_pkg::clamp_size(raw_width, 32'(bpd_pkg::MAX_WIDTH));
  assign pad_prod      = bit_count[4:3] * width_clamped[1:0];

  assign push = accept && parse_active && !in_first && !in_header && in_image &&
                (pad_left == '0) && (byte_phase == bpd_pkg::PH_RED);

  always_comb begin
    push_data.red        = in_byte;
    push_data.green      = held_green;
    push_data.blue       = held_blue;
    push_data.column     = col_counter;
    push_data.row        = row_counter[bpd_pkg::POS_W-1:0];
    push_data.last_pixel = col_last && row_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_active <= 1'b0;
      header_count <= '0;
      image_width  <= '0;
      image_height <= '0;
      pad_length   <= '0;
      pad_left     <= '0;
      col_counter  <= '0;
      row_counter  <= '0;
      byte_phase   <= bpd_pkg::PH_BLUE;
    end else if (accept && in_first) begin
      parse_active <= 1'b1;
      header_count <= bpd_pkg::HCNT_W'(1);
      image_width  <= '0;
      image_height <= '0;
      pad_length   <= '0;
      pad_left     <= '0;
      col_counter  <= '0;
      row_counter  <= '0;
      byte_phase   <= bpd_pkg::PH_BLUE;
    end else if (accept && parse_active) begin
      if (in_header) begin
        if (width_idx < bpd_pkg::FIELD_BYTES) begin
          raw_width[{width_idx[1:0], 3'b000} +: 8] <= in_byte;
        end else if (height_idx < bpd_pkg::FIELD_BYTES) begin
          raw_height[{height_idx[1:0], 3'b000} +: 8] <= in_byte;
        end else if (bits_idx < bpd_pkg::BITS_BYTES) begin
          bit_count[{bits_idx[0], 3'b000} +: 8] <= in_byte;
        end
        header_count <= header_count + 1'b1;
        if (header_count == bpd_pkg::HEADER_LEN - 1'b1) begin
          image_width  <= width_clamped;
          image_height <= bpd_pkg::clamp_size(raw_height, 32'(bpd_pkg::MAX_HEIGHT));
          pad_length   <= 2'd0 - pad_prod;
        end
      end else if (in_image) begin
        if (pad_left != '0) begin
          pad_left <= pad_left - 1'b1;
        end else begin
          unique case (byte_phase)
            bpd_pkg::PH_BLUE: begin
              held_blue  <= in_byte;
              byte_phase <= bpd_pkg::PH_GREEN;
            end
            bpd_pkg::PH_GREEN: begin
              held_green <= in_byte;
              byte_phase <= bpd_pkg::PH_RED;
            end
            default: begin
              byte_phase <= bpd_pkg::PH_BLUE;
              if (col_last) begin
                col_counter <= '0;
                row_counter <= row_counter + 1'b1;
                pad_left    <= pad_length;
              end else begin
                col_counter <= col_counter + 1'b1;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

/* src/bpd_queue.sv */
`timescale 1ns / 1ps
// Two-entry pixel queue between the parser and the output stage.
// Depends on bpd_pkg.
module bpd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bpd_pkg::pixel_t        push_data,
  input  logic                   pop,
  output bpd_pkg::pixel_t        pop_data,
  output bpd_pkg::queue_status_t status
);

  bpd_pkg::pixel_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign pop_data     = entries[rd_ptr];
  assign status.full  = count == 2'd2;
  assign status.empty = count == 2'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/bpd_emitter.sv */
`timescale 1ns / 1ps
// Back part: output register that presents queued pixels on the master stream.
// Depends on bpd_pkg; reads from bpd_queue.
module bpd_emitter (
  input  logic                   clk,
  input  logic                   rst,
  input  bpd_pkg::queue_status_t q_status,
  input  bpd_pkg::pixel_t        q_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [47:0]            out_data,
  output logic                   out_last
);

  assign pop = !q_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {q_data.row, q_data.column, q_data.blue, q_data.green, q_data.red};
      out_last <= q_data.last_pixel;
    end
  end

endmodule

/* src/bmp_pixel_stream_decoder.sv */
`timescale 1ns / 1ps
// Top level of the BMP pixel stream decoder.
// Depends on bpd_pkg, bpd_parser, bpd_queue and bpd_emitter.
//
// Usage: the slave stream carries one byte of a BMP file per request, with
// tuser high on the first byte of a file. The 54-byte header is parsed for
// width, height and bit count; the pixel bytes that follow (blue, green, red)
// are assembled into pixels, and row padding is skipped. Each pixel leaves on
// the master stream with its column and row; tlast marks the final pixel.
// Bytes before the first tuser mark and after the last pixel are dropped.
// Throughput is one byte per cycle while s_tready is high. A pixel enters
// the two-entry queue as its red byte is accepted, then the output register;
// these decouple the sides: when the receiver stalls, the queue fills and
// s_tready drops until an entry frees up. Reset clears the parse counters;
// the block then ignores input until a byte marked as first arrives.
module bmp_pixel_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                 // [35:24] column, [47:36] row
  output logic        m_tlast    // last_pixel
);

  bpd_pkg::queue_status_t q_status;
  bpd_pkg::pixel_t        push_data;
  bpd_pkg::pixel_t        pop_data;
  logic                   push;
  logic                   pop;

  bpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_first  (s_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  bpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  bpd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* test/bpd_pixel_checker.sv */
`timescale 1ns / 1ps
// Pixel checker for the BMP pixel stream decoder: watches both streams, predicts
// each decoded pixel from the accepted bytes and compares it field by field.
// Depends on bpd_pkg for the pixel type, the header offsets and the size limits.
module bpd_pixel_checker
  import bpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic        m_tlast,
  output int          errors,
  output int          pending
);

  logic [HCNT_W-1:0] hdr_cnt;
  logic [31:0]       raw_w;
  logic [31:0]       raw_h;
  logic [15:0]       bpp;
  logic [DIM_W-1:0]  img_w;
  logic [DIM_W-1:0]  img_h;
  logic [1:0]        pad_len;
  logic [1:0]        pad_left;
  logic [DIM_W-1:0]  col_cnt;
  logic [DIM_W-1:0]  row_cnt;
  phase_t            phase;
  logic [7:0]        held_b;
  logic [7:0]        held_g;
  logic              active;
  pixel_t            pixel_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic restart_parse();
    hdr_cnt  = '0;
    raw_w    = '0;
    raw_h    = '0;
    bpp      = '0;
    img_w    = '0;
    img_h    = '0;
    pad_len  = '0;
    pad_left = '0;
    col_cnt  = '0;
    row_cnt  = '0;
    phase    = PH_BLUE;
    held_b   = '0;
    held_g   = '0;
  endtask

  function automatic logic [DIM_W-1:0] fit_dim(input logic [31:0] raw,
                                               input int unsigned lim);
    if (raw[31]) begin
      return '0;
    end else if (raw > lim) begin
      return DIM_W'(lim);
    end
    return raw[DIM_W-1:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic first);
    pixel_t     px;
    logic [1:0] prod;
    if (first) begin
      restart_parse();
      active = 1'b1;
    end
    if (!active) begin
      return;
    end
    if (hdr_cnt < HEADER_LEN) begin
      if (hdr_cnt >= WIDTH_OFS && hdr_cnt < WIDTH_OFS + FIELD_BYTES) begin
        raw_w[(hdr_cnt - WIDTH_OFS) * 8 +: 8] = b;
      end else if (hdr_cnt >= HEIGHT_OFS && hdr_cnt < HEIGHT_OFS + FIELD_BYTES) begin
        raw_h[(hdr_cnt - HEIGHT_OFS) * 8 +: 8] = b;
      end else if (hdr_cnt >= BITS_OFS && hdr_cnt < BITS_OFS + BITS_BYTES) begin
        bpp[(hdr_cnt - BITS_OFS) * 8 +: 8] = b;
      end
      hdr_cnt = hdr_cnt + 1'b1;
      if (hdr_cnt == HEADER_LEN) begin
        img_w   = fit_dim(raw_w, MAX_WIDTH);
        img_h   = fit_dim(raw_h, MAX_HEIGHT);
        prod    = bpp[4:3] * img_w[1:0];
        pad_len = 2'd0 - prod;
      end
      return;
    end
    if (img_w == 0 || row_cnt >= img_h) begin
      return;
    end
    if (pad_left != 0) begin
      pad_left = pad_left - 2'd1;
      return;
    end
    case (phase)
      PH_BLUE: begin
        held_b = b;
        phase  = PH_GREEN;
      end
      PH_GREEN: begin
        held_g = b;
        phase  = PH_RED;
      end
      default: begin
        phase         = PH_BLUE;
        px.red        = b;
        px.green      = held_g;
        px.blue       = held_b;
        px.column     = col_cnt[POS_W-1:0];
        px.row        = row_cnt[POS_W-1:0];
        px.last_pixel = (col_cnt + 1 == img_w) && (row_cnt + 1 == img_h);
        pixel_q.push_back(px);
        col_cnt = col_cnt + 1'b1;
        if (col_cnt == img_w) begin
          col_cnt  = '0;
          row_cnt  = row_cnt + 1'b1;
          pad_left = pad_len;
        end
      end
    endcase
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst) begin
      restart_parse();
      active = 1'b0;
      pixel_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = pixel_t'({m_tlast, m_tdata});
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: pixel expected none, actual %p", $time, got);
        end else begin
          want = pixel_q.pop_front();
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("column", want.column, got.column);
          check_field("row", want.row, got.row);
          check_field("last_pixel", want.last_pixel, got.last_pixel);
        end
      end
      if (s_tvalid && s_tready) begin
        decode_byte(s_tdata, s_tuser);
      end
    end
    pending <= pixel_q.size();
  end

endmodule

/* test/bmp_pixel_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the BMP pixel stream decoder: streams bitmap files into the
// block under several idle and stall patterns and reports the verdict.
// Depends on bpd_pkg, bmp_pixel_stream_decoder and bpd_pixel_checker.
module bmp_pixel_stream_decoder_tb;
  import bpd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  int          errors;
  int          pending;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs      = 0;
  int          bytes_sent     = 0;

  bmp_pixel_stream_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  bpd_pixel_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // The receiver also serves long hold-off requests, so the block fills up.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (holds_done < hold_reqs) begin
        holds_done++;
        hold_left = 399;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic int image_bytes(input logic [31:0] w, input logic [31:0] h,
                                     input logic [15:0] bits);
    int unsigned ew;
    int unsigned eh;
    int unsigned pad;
    ew  = w[31] ? 0 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    eh  = h[31] ? 0 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    pad = (4 - ((bits / 8) * ew) % 4) % 4;
    return eh * (3 * ew + pad);
  endfunction

  // A fill below zero gives random body bytes; total counts from the first byte.
  task automatic send_file(input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] bits, input int total, input int fill);
    logic [7:0] b;
    for (int k = 0; k < total; k++) begin
      b = 8'($urandom);
      if (k >= WIDTH_OFS && k < WIDTH_OFS + FIELD_BYTES) begin
        b = w[(k - WIDTH_OFS) * 8 +: 8];
      end else if (k >= HEIGHT_OFS && k < HEIGHT_OFS + FIELD_BYTES) begin
        b = h[(k - HEIGHT_OFS) * 8 +: 8];
      end else if (k >= BITS_OFS && k < BITS_OFS + BITS_BYTES) begin
        b = bits[(k - BITS_OFS) * 8 +: 8];
      end else if (k >= HEADER_LEN && fill >= 0) begin
        b = 8'(fill);
      end
      push_byte(b, k == 0);
    end
  endtask

  task automatic random_files(input int budget);
    int          start;
    int          pick;
    int          full;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] bits;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      w    = $urandom_range(1, 9);
      h    = $urandom_range(1, 4);
      case ($urandom_range(5))
        0: bits = 16'd24;
        1: bits = 16'd32;
        2: bits = 16'd8;
        3: bits = 16'd16;
        4: bits = 16'd1;
        default: bits = 16'($urandom);
      endcase
      full = HEADER_LEN + image_bytes(w, h, bits);
      if (pick < 70) begin
        send_file(w, h, bits, full + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0),
                  -1);
      end else if (pick < 80) begin
        send_file(w, h, bits, $urandom_range(1, full - 1), -1);
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0: w = '0;
          1: h = '0;
          2: w = 32'h8000_0000 | $urandom;
          default: h = 32'h8000_0000 | $urandom;
        endcase
        send_file(w, h, bits, HEADER_LEN + $urandom_range(0, 12), -1);
      end else begin
        if ($urandom_range(1) == 0) begin
          w = 32'd4097 + $urandom_range(32'h7FFF_EFFE);
        end else begin
          h = 32'd4097 + $urandom_range(32'h7FFF_EFFE);
        end
        send_file(w, h, bits, HEADER_LEN + $urandom_range(3, 60), -1);
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    repeat (3) push_byte(8'($urandom), 1'b0);
    send_file(1, 1, 24, HEADER_LEN + image_bytes(1, 1, 24), 8'h00);
    send_file(1, 1, 24, HEADER_LEN + image_bytes(1, 1, 24), 8'hFF);
    send_file(2, 2, 24, HEADER_LEN + image_bytes(2, 2, 24), -1);
    send_file(3, 1, 32, HEADER_LEN + image_bytes(3, 1, 32), -1);
    send_file(0, 2, 24, HEADER_LEN + 6, -1);
    send_file(32'hFFFF_FFFE, 1, 24, HEADER_LEN + 6, -1);
    send_file(2, 32'h8000_0001, 24, HEADER_LEN + 6, -1);
    send_file(5, 2, 24, 20, -1);
    send_file(5, 2, 24, HEADER_LEN + 7, -1);
    send_file(2, 1, 16, HEADER_LEN + image_bytes(2, 1, 16) + 5, -1);

    hold_reqs <= hold_reqs + 1;
    random_files(250);
    send_file(32'h0000_2000, 1, 24, HEADER_LEN + 30, -1);
    send_file(1, 32'h7FFF_FFFF, 24, HEADER_LEN + 30, -1);

    send_idle_pct  <= 61;
    recv_stall_pct <= 0;
    random_files(250);
    send_idle_pct  <= 0;
    recv_stall_pct <= 61;
    random_files(250);
    send_idle_pct  <= 38;
    recv_stall_pct <= 38;
    random_files(250);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
